// ===== sv/fpa_pkg.sv =====
`default_nettype none

package fpa_pkg;

  localparam int FIELD_BITS = 32;
  localparam int FRAC_BITS = 8;
  localparam int WORD_BITS = 32;
  localparam int EFF_BITS = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
  localparam int PROD_BITS = 2 * EFF_BITS;
  localparam int NUM_BITS = EFF_BITS + FRAC_BITS;
  localparam int DIV_STEP = 4;
  localparam int DIV_STAGES = (NUM_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int QUOT_BITS = DIV_STAGES * DIV_STEP;
  localparam int MAG_BITS = PROD_BITS - FRAC_BITS;

  localparam logic signed [EFF_BITS-1:0] WORD_MAX = {1'b0, {(EFF_BITS-1){1'b1}}};
  localparam logic signed [EFF_BITS-1:0] WORD_MIN = {1'b1, {(EFF_BITS-1){1'b0}}};
  localparam logic [EFF_BITS-1:0] MAG_MAX = {1'b0, {(EFF_BITS-1){1'b1}}};

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_CMP     = 4'd4,
    OP_MIN     = 4'd5,
    OP_MAX     = 4'd6,
    OP_INC     = 4'd7,
    OP_DEC     = 4'd8,
    OP_FROM_INT = 4'd9,
    OP_TO_INT  = 4'd10
  } op_t;

  typedef struct packed {
    op_t                         op;
    logic                        lt;
    logic                        eq;
    logic                        gt;
    logic signed [EFF_BITS-1:0]  simple;
    logic                        simple_ovf;
    logic signed [PROD_BITS-1:0] prod;
    logic [QUOT_BITS-1:0]        quot;
    logic [EFF_BITS-1:0]         rem;
    logic [EFF_BITS-1:0]         den;
    logic                        q_neg;
    logic                        dbz;
  } stage_t;

  typedef struct packed {
    logic signed [EFF_BITS-1:0] value;
    logic                       ovf;
  } sat_t;

  function automatic sat_t sat_narrow(input logic signed [EFF_BITS:0] v);
    sat_t s;
    s.ovf = v[EFF_BITS] != v[EFF_BITS-1];
    if (s.ovf) begin
      s.value = v[EFF_BITS] ? WORD_MIN : WORD_MAX;
    end else begin
      s.value = v[EFF_BITS-1:0];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== sv/fpa_front.sv =====
`default_nettype none

module fpa_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [3:0]             op,
  input  wire logic signed [31:0]     operand_a,
  input  wire logic signed [31:0]     operand_b,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output fpa_pkg::stage_t             out_data
);

  localparam int W = fpa_pkg::EFF_BITS;
  localparam int F = fpa_pkg::FRAC_BITS;

  logic signed [W-1:0]   a;
  logic signed [W-1:0]   b;
  logic [W-1:0]          a_u;
  logic [W-1:0]          b_u;
  logic [W-1:0]          a_mag;
  logic signed [W+F-1:0] shifted;
  logic [F:0]            shifted_top;
  fpa_pkg::sat_t         sat_add;
  fpa_pkg::sat_t         sat_sub;
  fpa_pkg::sat_t         sat_inc;
  fpa_pkg::sat_t         sat_dec;
  fpa_pkg::stage_t       data_next;
  logic                  valid;

  always_comb begin
    a = operand_a[W-1:0];
    b = operand_b[W-1:0];
    a_u = operand_a[W-1:0];
    b_u = operand_b[W-1:0];
    a_mag = a[W-1] ? (~a_u + 1'b1) : a_u;

    sat_add = fpa_pkg::sat_narrow((W+1)'(a) + (W+1)'(b));
    sat_sub = fpa_pkg::sat_narrow((W+1)'(a) - (W+1)'(b));
    sat_inc = fpa_pkg::sat_narrow((W+1)'(a) + (W+1)'(1));
    sat_dec = fpa_pkg::sat_narrow((W+1)'(a) - (W+1)'(1));
    shifted = (W+F)'(a) <<< F;
    shifted_top = shifted[W+F-1:W-1];

    data_next.op = fpa_pkg::op_t'(op);
    data_next.lt = a < b;
    data_next.eq = a == b;
    data_next.gt = a > b;
    data_next.simple = '0;
    data_next.simple_ovf = 1'b0;
    case (fpa_pkg::op_t'(op))
      fpa_pkg::OP_ADD: begin
        data_next.simple = sat_add.value;
        data_next.simple_ovf = sat_add.ovf;
      end
      fpa_pkg::OP_SUB: begin
        data_next.simple = sat_sub.value;
        data_next.simple_ovf = sat_sub.ovf;
      end
      fpa_pkg::OP_MIN: data_next.simple = (a < b) ? a : b;
      fpa_pkg::OP_MAX: data_next.simple = (a > b) ? a : b;
      fpa_pkg::OP_INC: begin
        data_next.simple = sat_inc.value;
        data_next.simple_ovf = sat_inc.ovf;
      end
      fpa_pkg::OP_DEC: begin
        data_next.simple = sat_dec.value;
        data_next.simple_ovf = sat_dec.ovf;
      end
      fpa_pkg::OP_FROM_INT: begin
        if ((&shifted_top) || !(|shifted_top)) begin
          data_next.simple = shifted[W-1:0];
        end else begin
          data_next.simple = a[W-1] ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
          data_next.simple_ovf = 1'b1;
        end
      end
      fpa_pkg::OP_TO_INT: data_next.simple = a >>> F;
      default: begin
        data_next.simple = '0;
        data_next.simple_ovf = 1'b0;
      end
    endcase

    data_next.prod = fpa_pkg::PROD_BITS'(a) * fpa_pkg::PROD_BITS'(b);
    data_next.quot = fpa_pkg::QUOT_BITS'(a_mag) << F;
    data_next.rem = '0;
    data_next.den = b[W-1] ? (~b_u + 1'b1) : b_u;
    data_next.q_neg = a[W-1] ^ b[W-1];
    data_next.dbz = b == 0;
  end

  assign in_ready = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/fpa_div_stage.sv =====
`default_nettype none

module fpa_div_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire fpa_pkg::stage_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output fpa_pkg::stage_t      out_data
);

  localparam int W = fpa_pkg::EFF_BITS;
  localparam int Q = fpa_pkg::QUOT_BITS;

  fpa_pkg::stage_t data_next;
  logic [W:0]      wide;
  logic [Q-1:0]    quot;
  logic [W-1:0]    rem;
  logic            valid;

  // restoring division, a few quotient bits per stage
  always_comb begin
    quot = in_data.quot;
    rem = in_data.rem;
    wide = '0;
    for (int k = 0; k < fpa_pkg::DIV_STEP; k++) begin
      wide = {rem, quot[Q-1]};
      quot = {quot[Q-2:0], 1'b0};
      if (wide >= {1'b0, in_data.den}) begin
        rem = W'(wide - {1'b0, in_data.den});
        quot[0] = 1'b1;
      end else begin
        rem = wide[W-1:0];
      end
    end
    data_next = in_data;
    data_next.quot = quot;
    data_next.rem = rem;
  end

  assign in_ready = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/fpa_back.sv =====
`default_nettype none

module fpa_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire fpa_pkg::stage_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic signed [31:0]   result,
  output logic                 less,
  output logic                 equal,
  output logic                 greater,
  output logic                 overflow,
  output logic                 divide_by_zero
);

  localparam int W = fpa_pkg::EFF_BITS;
  localparam int F = fpa_pkg::FRAC_BITS;
  localparam int P = fpa_pkg::PROD_BITS;
  localparam int Q = fpa_pkg::QUOT_BITS;
  localparam int M = fpa_pkg::MAG_BITS;

  typedef struct packed {
    fpa_pkg::op_t        op;
    logic                lt;
    logic                eq;
    logic                gt;
    logic signed [W-1:0] simple;
    logic                simple_ovf;
    logic [P-1:0]        pmag;
    logic                p_neg;
    logic [Q-1:0]        qr;
    logic                q_neg;
    logic                dbz;
  } mag_t;

  typedef struct packed {
    fpa_pkg::op_t        op;
    logic                lt;
    logic                eq;
    logic                gt;
    logic signed [W-1:0] simple;
    logic                simple_ovf;
    logic [M-1:0]        m;
    logic                p_neg;
    logic signed [W-1:0] dres;
    logic                dovf;
    logic                dbz;
  } rnd_t;

  mag_t                s1;
  mag_t                s1_next;
  rnd_t                s2;
  rnd_t                s2_next;
  logic                v1;
  logic                v2;
  logic                v3;
  logic                rdy1;
  logic                rdy2;
  logic                rdy3;
  logic [P-1:0]        prod_u;
  logic [P-1:0]        psum;
  logic [Q-1:0]        qlim;
  logic [M-1:0]        mlim;
  logic [W-1:0]        qlow;
  logic [W-1:0]        mlow;
  logic signed [W-1:0] mres;
  logic                movf;
  logic signed [W-1:0] fres;
  logic                fovf;

  // stage 1: product magnitude, quotient rounding
  always_comb begin
    prod_u = in_data.prod;
    s1_next.op = in_data.op;
    s1_next.lt = in_data.lt;
    s1_next.eq = in_data.eq;
    s1_next.gt = in_data.gt;
    s1_next.simple = in_data.simple;
    s1_next.simple_ovf = in_data.simple_ovf;
    s1_next.p_neg = prod_u[P-1];
    s1_next.pmag = prod_u[P-1] ? (~prod_u + 1'b1) : prod_u;
    s1_next.qr = in_data.quot
        + Q'({in_data.rem, 1'b0} >= {1'b0, in_data.den});
    s1_next.q_neg = in_data.q_neg;
    s1_next.dbz = in_data.dbz;
  end

  // stage 2: product rounding, quotient sign and saturation
  always_comb begin
    psum = s1.pmag + (P'(1) << (F - 1));
    qlim = Q'(fpa_pkg::MAG_MAX) + Q'(s1.q_neg);
    qlow = s1.qr[W-1:0];
    s2_next.op = s1.op;
    s2_next.lt = s1.lt;
    s2_next.eq = s1.eq;
    s2_next.gt = s1.gt;
    s2_next.simple = s1.simple;
    s2_next.simple_ovf = s1.simple_ovf;
    s2_next.m = psum[P-1:F];
    s2_next.p_neg = s1.p_neg;
    s2_next.dbz = s1.dbz;
    if (s1.dbz) begin
      s2_next.dres = '0;
      s2_next.dovf = 1'b0;
    end else if (s1.qr > qlim) begin
      s2_next.dres = s1.q_neg ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
      s2_next.dovf = 1'b1;
    end else begin
      s2_next.dres = s1.q_neg ? (~qlow + 1'b1) : qlow;
      s2_next.dovf = 1'b0;
    end
  end

  // stage 3: product saturation and result select
  always_comb begin
    mlim = M'(fpa_pkg::MAG_MAX) + M'(s2.p_neg);
    mlow = s2.m[W-1:0];
    if (s2.m > mlim) begin
      mres = s2.p_neg ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
      movf = 1'b1;
    end else begin
      mres = s2.p_neg ? (~mlow + 1'b1) : mlow;
      movf = 1'b0;
    end
    case (s2.op)
      fpa_pkg::OP_MUL: begin
        fres = mres;
        fovf = movf;
      end
      fpa_pkg::OP_DIV: begin
        fres = s2.dres;
        fovf = s2.dovf;
      end
      default: begin
        fres = s2.simple;
        fovf = s2.simple_ovf;
      end
    endcase
  end

  assign rdy3 = !v3 || out_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1 <= s1_next;
    end
    if (rdy2) begin
      s2 <= s2_next;
    end
    if (rdy3) begin
      result <= 32'(fres);
      less <= s2.lt;
      equal <= s2.eq;
      greater <= s2.gt;
      overflow <= fovf;
      divide_by_zero <= s2.op == fpa_pkg::OP_DIV && s2.dbz;
    end
  end

endmodule

`default_nettype wire

// ===== sv/fixed_point_alu_top.sv =====
// channel  signals                                        beat
// -------  ---------------------------------------------  ----------------------------
// in       in_valid, in_ready, op, operand_a, operand_b    one operation
// out      out_valid, out_ready, result, less, equal,       one result word and flags
//          greater, overflow, divide_by_zero
//
// beats pass fpa_front, divider stages and fpa_back; 32-bit words, 8 fraction bits
// one beat per cycle enters while in_ready is high; 4 quotient bits per divider stage
// synchronous active-high rst clears the valid bits of every stage
// each stage holds while its successor is full and stalled; empty stages still fill

`default_nettype none

module fixed_point_alu_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         op,
  input  wire logic signed [31:0] operand_a,
  input  wire logic signed [31:0] operand_b,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      result,
  output logic                    less,
  output logic                    equal,
  output logic                    greater,
  output logic                    overflow,
  output logic                    divide_by_zero
);

  localparam int N = fpa_pkg::DIV_STAGES;

  fpa_pkg::stage_t data [N+1];
  logic            valid [N+1];
  logic            ready [N+1];

  fpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (valid[0]),
    .out_ready (ready[0]),
    .out_data  (data[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_div
    fpa_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[i]),
      .in_ready  (ready[i]),
      .in_data   (data[i]),
      .out_valid (valid[i+1]),
      .out_ready (ready[i+1]),
      .out_data  (data[i+1])
    );
  end

  fpa_back u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (valid[N]),
    .in_ready       (ready[N]),
    .in_data        (data[N]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result         (result),
    .less           (less),
    .equal          (equal),
    .greater        (greater),
    .overflow       (overflow),
    .divide_by_zero (divide_by_zero)
  );

  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({less, equal, greater}))
    else $error("comparison flags not one-hot");

  a_dbz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> result == 0 && !overflow)
    else $error("divide by zero beat with nonzero result or overflow");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output side not blocked");

endmodule

`default_nettype wire

// ===== test/fixed_point_alu_checker.sv =====
`timescale 1ns / 100ps

module fixed_point_alu_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [3:0]         op,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] result,
  input  logic               less,
  input  logic               equal,
  input  logic               greater,
  input  logic               overflow,
  input  logic               divide_by_zero,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  typedef struct packed {
    logic signed [31:0] result;
    logic               less;
    logic               equal;
    logic               greater;
    logic               overflow;
    logic               divide_by_zero;
  } alu_result_t;

  alu_result_t pending_results[$];
  int          errors = 0;
  int          compared = 0;

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
  end

  function automatic logic signed [31:0] clamp_word(input logic signed [63:0] v,
                                                    output logic ovf);
    ovf = 1'b0;
    if (v > fpa_pkg::WORD_MAX) begin
      ovf = 1'b1;
      return fpa_pkg::WORD_MAX;
    end
    if (v < fpa_pkg::WORD_MIN) begin
      ovf = 1'b1;
      return fpa_pkg::WORD_MIN;
    end
    return v[31:0];
  endfunction

  function automatic alu_result_t fixed_point_eval(input logic [3:0] code,
                                                   input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    alu_result_t r;
    logic signed [63:0] wa, wb, wide, prod;
    logic [63:0] mag, num, den;
    logic ovf;
    r = '0;
    wa = a;
    wb = b;
    wide = '0;
    r.less = a < b;
    r.equal = a == b;
    r.greater = a > b;
    case (code)
      fpa_pkg::OP_ADD: wide = wa + wb;
      fpa_pkg::OP_SUB: wide = wa - wb;
      fpa_pkg::OP_MUL: begin
        prod = wa * wb;
        mag = (prod < 0) ? -prod : prod;
        mag = (mag + (64'd1 << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS;
        wide = $signed(mag);
        if (prod < 0) wide = -wide;
      end
      fpa_pkg::OP_DIV: begin
        if (wb == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          num = (wa < 0) ? -wa : wa;
          num = num << fpa_pkg::FRAC_BITS;
          den = (wb < 0) ? -wb : wb;
          wide = $signed((64'd2 * num + den) / (64'd2 * den));
          if ((wa < 0) != (wb < 0)) wide = -wide;
        end
      end
      fpa_pkg::OP_CMP: wide = '0;
      fpa_pkg::OP_MIN: wide = (wa < wb) ? wa : wb;
      fpa_pkg::OP_MAX: wide = (wa > wb) ? wa : wb;
      fpa_pkg::OP_INC: wide = wa + 1;
      fpa_pkg::OP_DEC: wide = wa - 1;
      fpa_pkg::OP_FROM_INT: wide = wa <<< fpa_pkg::FRAC_BITS;
      fpa_pkg::OP_TO_INT: wide = wa >>> fpa_pkg::FRAC_BITS;
      default: wide = '0;
    endcase
    r.result = clamp_word(wide, ovf);
    r.overflow = ovf;
    return r;
  endfunction

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    alu_result_t want;
    if (rst) begin
      pending_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        pending_results.push_back(fixed_point_eval(op, operand_a, operand_b));
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no operation pending");
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("result", want.result, result);
          check_field("less", want.less, less);
          check_field("equal", want.equal, equal);
          check_field("greater", want.greater, greater);
          check_field("overflow", want.overflow, overflow);
          check_field("divide_by_zero", want.divide_by_zero, divide_by_zero);
          compared++;
        end
      end
    end
    fail_count <= errors;
    pending <= pending_results.size();
    checked <= compared;
  end

endmodule

// ===== test/tb_fixed_point_alu_top.sv =====
`timescale 1ns / 100ps

module tb_fixed_point_alu_top;

  localparam int          RANDOM_OPS = 1600;
  localparam int          PRESSURE_AT = 700;
  localparam int          PRESSURE_OPS = 60;
  localparam int          HOLD_CYCLES = 300;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES = 30;
  localparam logic [3:0]  OP_UNDEF_LO = 4'd11;
  localparam logic [3:0]  OP_UNDEF_HI = 4'd15;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [3:0]         op;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] result;
  logic               less;
  logic               equal;
  logic               greater;
  logic               overflow;
  logic               divide_by_zero;

  int fail_count;
  int pending;
  int checked;
  int sent_count = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fixed_point_alu_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result(result),
    .less(less),
    .equal(equal),
    .greater(greater),
    .overflow(overflow),
    .divide_by_zero(divide_by_zero)
  );

  fixed_point_alu_checker checker_i (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result(result),
    .less(less),
    .equal(equal),
    .greater(greater),
    .overflow(overflow),
    .divide_by_zero(divide_by_zero),
    .fail_count(fail_count),
    .pending(pending),
    .checked(checked)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6: v = $urandom_range(0, 8191) - 4096;
      7: begin
        case ($urandom_range(0, 6))
          0: v = fpa_pkg::WORD_MAX;
          1: v = fpa_pkg::WORD_MIN;
          2: v = '0;
          3: v = 32'sd1;
          4: v = -32'sd1;
          5: v = fpa_pkg::WORD_MAX - 1;
          default: v = fpa_pkg::WORD_MIN + 1;
        endcase
      end
      8: v = $signed($urandom) >>> $urandom_range(0, 30);
      default: begin
        v = 32'd1 << $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [3:0] random_code();
    if ($urandom_range(0, 99) < 94) begin
      return 4'($urandom_range(fpa_pkg::OP_ADD, fpa_pkg::OP_TO_INT));
    end
    return 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
  endfunction

  task automatic send_op(input logic [3:0] code, input logic [31:0] a, input logic [31:0] b);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_random();
    logic [31:0] a;
    logic [31:0] b;
    a = random_operand();
    b = ($urandom_range(0, 7) == 0) ? a : random_operand();
    send_op(random_code(), a, b);
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    int burst;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = calm ? 0 : pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        burst = $urandom_range(1, 20);
        repeat (burst) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    op <= fpa_pkg::OP_ADD;
    operand_a <= '0;
    operand_b <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // saturation, rounding and the special cases
    send_op(fpa_pkg::OP_ADD, fpa_pkg::WORD_MAX, fpa_pkg::WORD_MAX);
    send_op(fpa_pkg::OP_ADD, fpa_pkg::WORD_MIN, fpa_pkg::WORD_MIN);
    send_op(fpa_pkg::OP_ADD, 32'sd1, -32'sd1);
    send_op(fpa_pkg::OP_SUB, fpa_pkg::WORD_MIN, 32'sd1);
    send_op(fpa_pkg::OP_SUB, fpa_pkg::WORD_MAX, -32'sd1);
    send_op(fpa_pkg::OP_MUL, fpa_pkg::WORD_MAX, fpa_pkg::WORD_MAX);
    send_op(fpa_pkg::OP_MUL, fpa_pkg::WORD_MIN, fpa_pkg::WORD_MIN);
    send_op(fpa_pkg::OP_MUL, 32'sd1, 32'sd128);
    send_op(fpa_pkg::OP_MUL, -32'sd1, 32'sd128);
    send_op(fpa_pkg::OP_MUL, 32'sh0000_0180, -32'sh0000_0280);
    send_op(fpa_pkg::OP_DIV, 32'sd5, '0);
    send_op(fpa_pkg::OP_DIV, '0, '0);
    send_op(fpa_pkg::OP_DIV, fpa_pkg::WORD_MIN, -32'sd1);
    send_op(fpa_pkg::OP_DIV, 32'sh0000_0100, 32'sh0000_0300);
    send_op(fpa_pkg::OP_DIV, -32'sd1, 32'sd2);
    send_op(fpa_pkg::OP_CMP, 32'sd7, 32'sd7);
    send_op(fpa_pkg::OP_MIN, fpa_pkg::WORD_MIN, fpa_pkg::WORD_MAX);
    send_op(fpa_pkg::OP_MAX, fpa_pkg::WORD_MIN, fpa_pkg::WORD_MAX);
    send_op(fpa_pkg::OP_INC, fpa_pkg::WORD_MAX, '0);
    send_op(fpa_pkg::OP_DEC, fpa_pkg::WORD_MIN, '0);
    send_op(fpa_pkg::OP_FROM_INT, fpa_pkg::WORD_MAX, '0);
    send_op(fpa_pkg::OP_FROM_INT, -32'sd5, '0);
    send_op(fpa_pkg::OP_TO_INT, -32'sd1, '0);
    send_op(fpa_pkg::OP_TO_INT, fpa_pkg::WORD_MIN, fpa_pkg::WORD_MAX);
    send_op(OP_UNDEF_LO, 32'sd3, -32'sd3);
    send_op(OP_UNDEF_HI, fpa_pkg::WORD_MAX, fpa_pkg::WORD_MIN);

    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 4) == 0);
      if (i == PRESSURE_AT) begin
        calm = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < PRESSURE_OPS; k++) send_random();
        calm = 1'b0;
      end
      send_random();
    end
    in_valid <= 1'b0;

    while (checked < sent_count || pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d operations driven, %0d results checked over all opcodes and reserved codes",
             sent_count, checked);
    $display("run included saturation, rounding, divide by zero and a long output hold-off");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
